// ===== src/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and constants for the YUV 4:2:2 to RGB converter
// BT.601 coefficients scaled by 65536, product and sum types, and the
// scale-and-clip helper used on every color channel.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 19;   // 18-bit magnitudes plus sign
    localparam int DIFF_W   = 9;    // offset-removed sample, signed
    localparam int PROD_W   = COEF_W + DIFF_W;
    localparam int FRAC_W   = 16;

    localparam logic signed [COEF_W-1:0] LUMA_K  = 19'sd76284;
    localparam logic signed [COEF_W-1:0] CB_TO_B = 19'sd132252;
    localparam logic signed [COEF_W-1:0] CR_TO_G = 19'sd53281;
    localparam logic signed [COEF_W-1:0] CB_TO_G = 19'sd25625;
    localparam logic signed [COEF_W-1:0] CR_TO_R = 19'sd104595;

    localparam logic [SAMPLE_W-1:0] LUMA_FLOOR = 8'd16;
    localparam logic [SAMPLE_W-1:0] CHROMA_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] CHAN_MAX   = 8'd255;

    localparam logic ORDER_RGB = 1'b0;
    localparam logic ORDER_BGR = 1'b1;

    typedef logic [SAMPLE_W-1:0]      t_sample;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Handshake-side control shared by the pipeline stages
    typedef struct packed {
        logic advance;      // every stage moves one step
        logic pixel_order;  // ORDER_RGB or ORDER_BGR
    } t_pipe_ctl;

    // Floor shift by 16 then clip to 0..255; negative sums give 0.
    function automatic t_sample scale_clip(input t_prod sum);
        t_sample res;
        if (sum[PROD_W-1]) begin
            res = '0;
        end else if (|sum[PROD_W-2:FRAC_W+SAMPLE_W]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

// ===== src/y2r_pixel.sv =====
// ----------------------------------------------------------------------------
// y2r_pixel: channel sums and clipping for one pixel
// Adds the registered coefficient products into B, G and R sums, then
// clips each to a byte, forces dark pixels to black and orders the bytes.
// ----------------------------------------------------------------------------
module y2r_pixel (
    input  logic               i_clk,
    input  y2r_pkg::t_pipe_ctl i_ctl,
    input  y2r_pkg::t_prod     i_luma_prod,
    input  y2r_pkg::t_prod     i_cb_to_b,
    input  y2r_pkg::t_prod     i_cr_to_g,
    input  y2r_pkg::t_prod     i_cb_to_g,
    input  y2r_pkg::t_prod     i_cr_to_r,
    input  logic               i_dark,
    output y2r_pkg::t_sample   o_byte0,
    output y2r_pkg::t_sample   o_byte1,
    output y2r_pkg::t_sample   o_byte2
);
    import y2r_pkg::*;

    t_prod   r_sum_b, r_sum_g, r_sum_r;
    logic    r_dark;
    t_sample r_byte0, r_byte1, r_byte2;
    t_sample n_b, n_g, n_r;

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_sum_b <= i_luma_prod + i_cb_to_b;
            r_sum_g <= i_luma_prod - i_cr_to_g - i_cb_to_g;
            r_sum_r <= i_luma_prod + i_cr_to_r;
            r_dark  <= i_dark;
        end
    end

    always_comb begin
        n_b = r_dark ? '0 : scale_clip(r_sum_b);
        n_g = r_dark ? '0 : scale_clip(r_sum_g);
        n_r = r_dark ? '0 : scale_clip(r_sum_r);
    end

    // Clip and order stage, registered straight onto the outputs
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_byte1 <= n_g;
            if (i_ctl.pixel_order == ORDER_BGR) begin
                r_byte0 <= n_b;
                r_byte2 <= n_r;
            end else begin
                r_byte0 <= n_r;
                r_byte2 <= n_b;
            end
        end
    end

    assign o_byte0 = r_byte0;
    assign o_byte1 = r_byte1;
    assign o_byte2 = r_byte2;

endmodule

// ===== src/yuv422_pair_to_rgb.sv =====
// ----------------------------------------------------------------------------
// yuv422_pair_to_rgb: YUV 4:2:2 pixel pair to two 24-bit RGB pixels
//
//   channel   dir  handshake               payload
//   s_*       in   s_tvalid / s_tready     s_tdata: luma pair, U, V
//   m_*       out  m_tvalid / m_tready     m_tdata: two pixels, 3 bytes each
//   cfg       in   i_cfg_valid/o_cfg_ready i_cfg_data: pixel_order
//
// Four register stages: offset removal, products, channel sums, clip/order.
// One item per cycle enters and leaves when unstalled.
// A stall on m_tready freezes all stages together; nothing is dropped.
// Synchronous active-low reset clears the stage valid bits and pixel_order.
// ----------------------------------------------------------------------------
module yuv422_pair_to_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // luma_first, luma_second, chroma_blue, chroma_red
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // first_byte0..2, second_byte0..2
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import y2r_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] r_valid;
    logic              r_pixel_order;
    logic              adv;
    t_pipe_ctl         ctl;

    t_diff r_d1, r_d2, r_cb, r_cr;
    logic  r_dark1_s1, r_dark2_s1;
    t_prod r_yk1, r_yk2, r_bcb, r_gcr, r_gcb, r_rcr;
    logic  r_dark1_s2, r_dark2_s2;

    t_sample luma_first, luma_second, chroma_blue, chroma_red;
    t_sample f_b0, f_b1, f_b2, s_b0, s_b1, s_b2;

    assign luma_first  = s_tdata[7:0];
    assign luma_second = s_tdata[15:8];
    assign chroma_blue = s_tdata[23:16];
    assign chroma_red  = s_tdata[31:24];

    // Whole pipeline advances when the output slot is free or being taken
    assign adv      = !r_valid[STAGES-1] || m_tready;
    assign s_tready = adv;
    assign ctl      = '{advance: adv, pixel_order: r_pixel_order};

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_order <= ORDER_RGB;
        end else if (i_cfg_valid) begin
            r_pixel_order <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[STAGES-2:0], s_tvalid};
        end
    end

    // Offset removal
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1       <= t_diff'({1'b0, luma_first})  - t_diff'({1'b0, LUMA_FLOOR});
            r_d2       <= t_diff'({1'b0, luma_second}) - t_diff'({1'b0, LUMA_FLOOR});
            r_cb       <= t_diff'({1'b0, chroma_blue}) - t_diff'({1'b0, CHROMA_MID});
            r_cr       <= t_diff'({1'b0, chroma_red})  - t_diff'({1'b0, CHROMA_MID});
            r_dark1_s1 <= luma_first  <= LUMA_FLOOR;
            r_dark2_s1 <= luma_second <= LUMA_FLOOR;
        end
    end

    // Coefficient products; chroma terms are shared by both pixels
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yk1      <= LUMA_K  * r_d1;
            r_yk2      <= LUMA_K  * r_d2;
            r_bcb      <= CB_TO_B * r_cb;
            r_gcr      <= CR_TO_G * r_cr;
            r_gcb      <= CB_TO_G * r_cb;
            r_rcr      <= CR_TO_R * r_cr;
            r_dark1_s2 <= r_dark1_s1;
            r_dark2_s2 <= r_dark2_s1;
        end
    end

    y2r_pixel u_first (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_luma_prod (r_yk1),
        .i_cb_to_b   (r_bcb),
        .i_cr_to_g   (r_gcr),
        .i_cb_to_g   (r_gcb),
        .i_cr_to_r   (r_rcr),
        .i_dark      (r_dark1_s2),
        .o_byte0     (f_b0),
        .o_byte1     (f_b1),
        .o_byte2     (f_b2)
    );

    y2r_pixel u_second (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_luma_prod (r_yk2),
        .i_cb_to_b   (r_bcb),
        .i_cr_to_g   (r_gcr),
        .i_cb_to_g   (r_gcb),
        .i_cr_to_r   (r_rcr),
        .i_dark      (r_dark2_s2),
        .o_byte0     (s_b0),
        .o_byte1     (s_b1),
        .o_byte2     (s_b2)
    );

    assign m_tvalid = r_valid[STAGES-1];
    assign m_tdata  = {s_b2, s_b1, s_b0, f_b2, f_b1, f_b0};

`ifndef SYNTHESIS
    // A stalled pipeline keeps every stage's occupancy
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_valid))
        else $error("pipeline occupancy changed during a stall");

    // An occupied sum stage reaches the output on an advance
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_valid[STAGES-2] |=> m_tvalid)
        else $error("item lost between sum stage and output");

    // An empty sum stage never shows up as a result
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_valid[STAGES-2] |=> !m_tvalid)
        else $error("result appeared from an empty stage");
`endif

endmodule

// ===== tb/yuv422_pair_to_rgb_tb.sv =====
// ----------------------------------------------------------------------------
// yuv422_pair_to_rgb_tb: self-checking bench for the YUV 4:2:2 pair converter
// Streams pixel pairs into the block and predicts both BT.601 pixels for each
// item in the bench. The order register is swept between RGB and BGR while the
// pipeline is idle. Random gaps on the input and random back-pressure on the
// output are applied, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module yuv422_pair_to_rgb_tb;

    import y2r_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int PIPE_DEPTH  = 4;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 380;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // luma_first, luma_second, chroma_blue, chroma_red
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // first_byte0..2, second_byte0..2
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    logic [47:0] pending_rgb_q[$];
    logic        rgb_order;
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    bit          steady_run   = 1'b0;

    string byte_name[6] = '{"first_byte0", "first_byte1", "first_byte2",
                            "second_byte0", "second_byte1", "second_byte2"};

    yuv422_pair_to_rgb dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic t_sample chan_clip(input longint sum);
        if (sum < 0) begin
            return '0;
        end
        if ((sum >>> 16) > 255) begin
            return CHAN_MAX;
        end
        return t_sample'(sum >>> 16);
    endfunction

    // Returns byte0 in the low bits
    function automatic logic [23:0] pixel_bytes(input t_sample y, input longint cb,
                                                input longint cr, input logic order);
        longint  d;
        t_sample r;
        t_sample g;
        t_sample b;
        r = '0;
        g = '0;
        b = '0;
        if (y > LUMA_FLOOR) begin
            d = longint'(y) - longint'(LUMA_FLOOR);
            b = chan_clip(longint'(LUMA_K) * d + longint'(CB_TO_B) * cb);
            g = chan_clip(longint'(LUMA_K) * d - longint'(CR_TO_G) * cr
                          - longint'(CB_TO_G) * cb);
            r = chan_clip(longint'(LUMA_K) * d + longint'(CR_TO_R) * cr);
        end
        return (order == ORDER_BGR) ? {r, g, b} : {b, g, r};
    endfunction

    function automatic logic [47:0] bt601_pair(input logic [31:0] pair, input logic order);
        longint cb;
        longint cr;
        cb = longint'(pair[23:16]) - longint'(CHROMA_MID);
        cr = longint'(pair[31:24]) - longint'(CHROMA_MID);
        return {pixel_bytes(pair[15:8], cb, cr, order), pixel_bytes(pair[7:0], cb, cr, order)};
    endfunction

    // ---------------- scoreboard ----------------

    // Push before pop so a result leaving in the same cycle as its input would still find its item
    always @(posedge i_clk) begin
        logic [47:0] want;
        int          k;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                pending_rgb_q.push_back(bt601_pair(s_tdata, rgb_order));
            end
            if (m_tvalid && m_tready) begin
                if (pending_rgb_q.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("unexpected item: m_tdata=%h", m_tdata);
                    end
                end else begin
                    want = pending_rgb_q.pop_front();
                    for (k = 0; k < 6; k++) begin
                        if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                            mismatch_cnt = mismatch_cnt + 1;
                            if (mismatch_cnt <= MAX_REPORTS) begin
                                $display("%s: expected %0d, got %0d (item %h)", byte_name[k],
                                         want[8*k +: 8], m_tdata[8*k +: 8], m_tdata);
                            end
                        end
                    end
                end
            end
        end
    end

    // Random back-pressure, off during the steady phase
    always @(posedge i_clk) begin
        m_tready <= steady_run || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    // Optional gap first, then hold the item until it is taken
    task automatic send_pair(input t_sample y_first, input t_sample y_second,
                             input t_sample u, input t_sample v);
        if (!steady_run && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u, y_second, y_first};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic flush_pipeline();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_rgb_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_order(input logic order);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= order;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rgb_order = order;
    endtask

    function automatic t_sample extreme_sample();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd16;
            3: return 8'd17;
            4: return 8'd127;
            5: return 8'd128;
            6: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Dark pixels, threshold on each luma separately, clip low and clip high
    task automatic send_corner_pairs();
        send_pair(8'd0,   8'd0,   8'd0,   8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd16,  8'd17,  8'd128, 8'd128);
        send_pair(8'd17,  8'd16,  8'd128, 8'd128);
        send_pair(8'd16,  8'd16,  8'd0,   8'd255);
        send_pair(8'd15,  8'd255, 8'd128, 8'd128);
        send_pair(8'd255, 8'd0,   8'd0,   8'd0);
        send_pair(8'd255, 8'd255, 8'd0,   8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0);
        send_pair(8'd255, 8'd255, 8'd0,   8'd255);
        send_pair(8'd17,  8'd17,  8'd0,   8'd0);
        send_pair(8'd17,  8'd17,  8'd255, 8'd255);
        send_pair(8'd17,  8'd17,  8'd255, 8'd0);
        send_pair(8'd17,  8'd17,  8'd0,   8'd255);
        send_pair(8'd235, 8'd235, 8'd240, 8'd240);
        send_pair(8'd235, 8'd16,  8'd16,  8'd16);
        send_pair(8'd128, 8'd200, 8'd128, 8'd128);
        send_pair(8'd81,  8'd145, 8'd90,  8'd240);
        send_pair(8'd41,  8'd210, 8'd240, 8'd110);
        send_pair(8'd170, 8'd106, 8'd166, 8'd16);
        send_pair(8'd255, 8'd254, 8'd1,   8'd254);
    endtask

    task automatic send_random_pair();
        t_sample y1;
        t_sample y2;
        t_sample u;
        t_sample v;
        int      kind;
        kind = $urandom_range(99);
        y1 = t_sample'($urandom);
        y2 = t_sample'($urandom);
        u  = t_sample'($urandom);
        v  = t_sample'($urandom);
        if (kind < 20) begin
            // lumas around the black threshold
            y1 = t_sample'($urandom_range(13, 20));
            y2 = t_sample'($urandom_range(13, 20));
        end else if (kind < 32) begin
            u = extreme_sample();
            v = extreme_sample();
        end else if (kind < 40) begin
            y1 = extreme_sample();
            y2 = extreme_sample();
        end
        send_pair(y1, y2, u, v);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_rgb();
        // order left at its reset value
        send_corner_pairs();
        flush_pipeline();
    endtask

    task automatic test_directed_bgr();
        write_order(ORDER_BGR);
        send_corner_pairs();
        flush_pipeline();
    endtask

    task automatic test_random_orders();
        int phase;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            write_order(phase[0] ? ORDER_BGR : ORDER_RGB);
            steady_run = (phase == 2);
            repeat (PHASE_ITEMS) send_random_pair();
            flush_pipeline();
            steady_run = 1'b0;
        end
    endtask

    initial begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        i_rst_n     <= 1'b0;
        rgb_order = ORDER_RGB;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_rgb();
        test_directed_bgr();
        test_random_orders();

        repeat (PIPE_DEPTH * 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_rgb_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/y2r_pkg.sv
src/y2r_pixel.sv
src/yuv422_pair_to_rgb.sv
tb/yuv422_pair_to_rgb_tb.sv
